[rtl/fasr_pkg.sv]
// fasr_pkg: shared types and constants for the fraction add/subtract/reduce block
// no dependencies; imported by fasr_cross, fraction_add_subtract_reduce and the bench

package fasr_pkg;

    // default width of each input numerator and denominator
    localparam int IN_WIDTH_DEF = 16;

    // result field widths, fixed by the item format
    localparam int NUM_W = 33;
    localparam int DEN_W = 32;

    // master-side tdata width, result fields padded to whole bytes
    localparam int M_TDATA_W = ((NUM_W + DEN_W + 7) / 8) * 8;

    // operation select carried in the slave-side tuser
    typedef enum logic [0:0] {
        OP_ADD = 1'b0,
        OP_SUB = 1'b1
    } t_op;

    // cross product sequencer phases
    typedef enum logic [1:0] {
        MP_IDLE,
        MP_P1,
        MP_P2,
        MP_DEN
    } t_mphase;

    // main sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CROSS,
        ST_TEST,
        ST_REM,
        ST_QNUM,
        ST_QDEN,
        ST_EMIT
    } t_state;

endpackage

[rtl/fasr_div.sv]
// fasr_div: shared restoring divider, one quotient bit per cycle
// unsigned quotient and remainder; used for every remainder step and both final divisions

module fasr_div #(
    parameter int W = 33
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_start,
    input  logic [W-1:0] i_dividend,
    input  logic [W-1:0] i_divisor,
    output logic         o_done,
    output logic [W-1:0] o_quo,
    output logic [W-1:0] o_rem
);

    localparam int CW = $clog2(W + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_quo;
    logic [W-1:0]  r_rem;
    logic [W-1:0]  r_div;

    logic [W:0]    trial;
    logic [W:0]    diff;
    logic          fits;

    // one shift-and-subtract step
    always_comb begin
        trial = {r_rem, r_quo[W-1]};
        diff  = trial - {1'b0, r_div};
        fits  = (trial >= {1'b0, r_div});
    end

    // control: bit counter and completion pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    // datapath: partial remainder and quotient shift register
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[W-2:0], fits};
            r_rem <= fits ? diff[W-1:0] : trial[W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
    assign o_rem  = r_rem;

endmodule

[rtl/fasr_cross.sv]
// fasr_cross: cross products num = a_num*b_den +/- b_num*a_den and den = a_den*b_den
// one shared signed multiplier used in turn for the three products; depends on fasr_pkg

module fasr_cross
    import fasr_pkg::*;
#(
    parameter int IN_WIDTH = IN_WIDTH_DEF,
    parameter int NW       = 2 * IN_WIDTH_DEF + 1
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  t_op                        i_kind,
    input  logic signed [IN_WIDTH-1:0] i_a_num,
    input  logic signed [IN_WIDTH-1:0] i_a_den,
    input  logic signed [IN_WIDTH-1:0] i_b_num,
    input  logic signed [IN_WIDTH-1:0] i_b_den,
    output logic                       o_done,
    output logic signed [NW-1:0]       o_num,
    output logic signed [NW-1:0]       o_den
);

    localparam int PW = 2 * IN_WIDTH;

    t_mphase                    r_phase;
    t_mphase                    n_phase;
    logic                       r_done;
    t_op                        r_kind;
    logic signed [IN_WIDTH-1:0] r_an;
    logic signed [IN_WIDTH-1:0] r_ad;
    logic signed [IN_WIDTH-1:0] r_bn;
    logic signed [IN_WIDTH-1:0] r_bd;
    logic signed [NW-1:0]       r_p1;
    logic signed [NW-1:0]       r_p2;
    logic signed [NW-1:0]       r_num;
    logic signed [NW-1:0]       r_den;

    logic signed [IN_WIDTH-1:0] op_x;
    logic signed [IN_WIDTH-1:0] op_y;
    logic signed [PW-1:0]       prod;

    // next phase
    always_comb begin
        case (r_phase)
            MP_IDLE: n_phase = i_start ? MP_P1 : MP_IDLE;
            MP_P1:   n_phase = MP_P2;
            MP_P2:   n_phase = MP_DEN;
            MP_DEN:  n_phase = MP_IDLE;
            default: n_phase = MP_IDLE;
        endcase
    end

    // multiplier operand selection per phase
    always_comb begin
        case (r_phase)
            MP_P1: begin
                op_x = r_an;
                op_y = r_bd;
            end
            MP_P2: begin
                op_x = r_bn;
                op_y = r_ad;
            end
            MP_DEN: begin
                op_x = r_ad;
                op_y = r_bd;
            end
            default: begin
                op_x = r_an;
                op_y = r_bd;
            end
        endcase
        prod = op_x * op_y;
    end

    // phase register and completion pulse
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= MP_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_done  <= (r_phase == MP_DEN);
        end
    end

    // operand capture and product registers
    always_ff @(posedge i_clk) begin
        if (r_phase == MP_IDLE && i_start) begin
            r_kind <= i_kind;
            r_an   <= i_a_num;
            r_ad   <= i_a_den;
            r_bn   <= i_b_num;
            r_bd   <= i_b_den;
        end
        if (r_phase == MP_P1) begin
            r_p1 <= NW'(prod);
        end
        if (r_phase == MP_P2) begin
            r_p2 <= NW'(prod);
        end
        if (r_phase == MP_DEN) begin
            r_den <= NW'(prod);
            r_num <= (r_kind == OP_SUB) ? r_p1 - r_p2 : r_p1 + r_p2;
        end
    end

    assign o_done = r_done;
    assign o_num  = r_num;
    assign o_den  = r_den;

endmodule

[rtl/fraction_add_subtract_reduce.sv]
// fraction_add_subtract_reduce: adds or subtracts two signed fractions and reduces by the gcd
// depends on fasr_pkg, fasr_cross and fasr_div
//
// channel   direction  fields (lowest bits first)
// s_axis    in         tdata: a_num, a_den, b_num, b_den, zero pad; tuser: kind
// m_axis    out        tdata: res_num, res_den, zero pad; tuser: zero_divide
//
// one item at a time: accept, three cross products, then k remainder steps
// of Euclid and two final divisions, each an NW-bit division on the bit-serial divider,
// where NW = 2*IN_WIDTH+1 (at most 64);
// the serial divider sets the time taken per item
// synchronous active-low reset clears the sequencers and the output valid
// a finished item waits in the output register; a new item is taken meanwhile

module fraction_add_subtract_reduce
    import fasr_pkg::*;
#(
    parameter int IN_WIDTH = IN_WIDTH_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // slave side
    input  logic                                 i_s_axis_tvalid,
    output logic                                 o_s_axis_tready,
    input  logic [((4*IN_WIDTH+7)/8)*8-1:0]      i_s_axis_tdata,  // a_num, a_den, b_num, b_den
    input  logic                                 i_s_axis_tuser,  // kind
    // master side
    output logic                                 o_m_axis_tvalid,
    input  logic                                 i_m_axis_tready,
    output logic [M_TDATA_W-1:0]                 o_m_axis_tdata,  // res_num, res_den
    output logic                                 o_m_axis_tuser   // zero_divide
);

    localparam int NW  = (2 * IN_WIDTH + 1 > 64) ? 64 : 2 * IN_WIDTH + 1;
    localparam int XW  = (NW > NUM_W) ? NW : NUM_W;
    localparam int PAD = M_TDATA_W - NUM_W - DEN_W;

    t_state               r_state;
    t_state               n_state;

    logic                 s_accept;
    logic                 cross_done;
    logic signed [NW-1:0] cross_num;
    logic signed [NW-1:0] cross_den;

    logic                 div_start;
    logic [NW-1:0]        div_dividend;
    logic [NW-1:0]        div_divisor;
    logic                 div_done;
    logic [NW-1:0]        div_quo;
    logic [NW-1:0]        div_rem;

    logic                 r_num_neg;
    logic                 r_den_neg;
    logic [NW-1:0]        r_num_mag;
    logic [NW-1:0]        r_den_mag;
    logic [NW-1:0]        r_prev;
    logic [NW-1:0]        r_cur;
    logic                 r_par;
    logic                 r_gneg;
    logic                 r_zero;
    logic [NW-1:0]        r_qn;
    logic [NW-1:0]        r_qd;

    logic                 r_m_valid;
    logic [NUM_W-1:0]     r_res_num;
    logic [DEN_W-1:0]     r_res_den;
    logic                 r_res_zero;

    logic                 load_out;
    logic                 neg_num;
    logic                 neg_den;
    logic [XW-1:0]        qn_x;
    logic [XW-1:0]        qd_x;
    logic [XW-1:0]        sn_x;
    logic [XW-1:0]        sd_x;

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign s_accept        = i_s_axis_tvalid && o_s_axis_tready;
    assign load_out        = (r_state == ST_EMIT) && (!r_m_valid || i_m_axis_tready);

    // cross product unit
    fasr_cross #(
        .IN_WIDTH (IN_WIDTH),
        .NW       (NW)
    ) u_cross (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (s_accept),
        .i_kind  (t_op'(i_s_axis_tuser)),
        .i_a_num ($signed(i_s_axis_tdata[IN_WIDTH-1:0])),
        .i_a_den ($signed(i_s_axis_tdata[2*IN_WIDTH-1 -: IN_WIDTH])),
        .i_b_num ($signed(i_s_axis_tdata[3*IN_WIDTH-1 -: IN_WIDTH])),
        .i_b_den ($signed(i_s_axis_tdata[4*IN_WIDTH-1 -: IN_WIDTH])),
        .o_done  (cross_done),
        .o_num   (cross_num),
        .o_den   (cross_den)
    );

    // shared serial divider
    fasr_div #(
        .W (NW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quo      (div_quo),
        .o_rem      (div_rem)
    );

    // next state
    always_comb begin
        case (r_state)
            ST_IDLE:  n_state = s_accept ? ST_CROSS : ST_IDLE;
            ST_CROSS: n_state = cross_done ? ST_TEST : ST_CROSS;
            ST_TEST: begin
                if (r_cur != '0) begin
                    n_state = ST_REM;
                end else if (r_prev == '0) begin
                    n_state = ST_EMIT;
                end else begin
                    n_state = ST_QNUM;
                end
            end
            ST_REM:   n_state = div_done ? ST_TEST : ST_REM;
            ST_QNUM:  n_state = div_done ? ST_QDEN : ST_QNUM;
            ST_QDEN:  n_state = div_done ? ST_EMIT : ST_QDEN;
            ST_EMIT:  n_state = load_out ? ST_IDLE : ST_EMIT;
            default:  n_state = ST_IDLE;
        endcase
    end

    // divider requests
    always_comb begin
        div_start    = 1'b0;
        div_dividend = r_prev;
        div_divisor  = r_cur;
        case (r_state)
            ST_TEST: begin
                if (r_cur != '0) begin
                    div_start = 1'b1;
                end else if (r_prev != '0) begin
                    div_start    = 1'b1;
                    div_dividend = r_num_mag;
                    div_divisor  = r_prev;
                end
            end
            ST_QNUM: begin
                div_start    = div_done;
                div_dividend = r_den_mag;
                div_divisor  = r_prev;
            end
            default: begin
                div_start = 1'b0;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // euclid terms, signs and quotients
    always_ff @(posedge i_clk) begin
        if (r_state == ST_CROSS && cross_done) begin
            r_num_neg <= cross_num[NW-1];
            r_den_neg <= cross_den[NW-1];
            r_num_mag <= cross_num[NW-1] ? NW'(-cross_num) : NW'(cross_num);
            r_den_mag <= cross_den[NW-1] ? NW'(-cross_den) : NW'(cross_den);
            r_prev    <= cross_num[NW-1] ? NW'(-cross_num) : NW'(cross_num);
            r_cur     <= cross_den[NW-1] ? NW'(-cross_den) : NW'(cross_den);
            r_par     <= 1'b1;
        end
        if (r_state == ST_TEST && r_cur == '0) begin
            r_gneg <= r_par ? r_num_neg : r_den_neg;
            r_zero <= (r_prev == '0);
        end
        if (r_state == ST_REM && div_done) begin
            r_prev <= r_cur;
            r_cur  <= div_rem;
            r_par  <= !r_par;
        end
        if (r_state == ST_QNUM && div_done) begin
            r_qn <= div_quo;
        end
        if (r_state == ST_QDEN && div_done) begin
            r_qd <= div_quo;
        end
    end

    // result signs and truncation to the output widths
    always_comb begin
        neg_num = (r_num_mag != '0) && (r_num_neg != r_gneg);
        neg_den = (r_den_mag != '0) && (r_den_neg != r_gneg);
        qn_x    = XW'(r_qn);
        qd_x    = XW'(r_qd);
        sn_x    = neg_num ? (XW'(0) - qn_x) : qn_x;
        sd_x    = neg_den ? (XW'(0) - qd_x) : qd_x;
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (load_out) begin
            r_m_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_res_zero <= r_zero;
            r_res_num  <= r_zero ? '0 : sn_x[NUM_W-1:0];
            r_res_den  <= r_zero ? '0 : sd_x[DEN_W-1:0];
        end
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = {{PAD{1'b0}}, r_res_den, r_res_num};
    assign o_m_axis_tuser  = r_res_zero;

endmodule

[tb/sv/tb_fraction_add_subtract_reduce.sv]
`timescale 1ns / 1ps
// tb_fraction_add_subtract_reduce: self-checking bench for the fraction add/subtract/reduce block
// sends directed and random operand items, predicts each reduced sum and checks every result
// depends on fasr_pkg and fraction_add_subtract_reduce

module tb_fraction_add_subtract_reduce;
    import fasr_pkg::*;

    localparam int W         = IN_WIDTH_DEF;
    localparam int S_TDATA_W = ((4*W+7)/8)*8;

    // one reduced result as it leaves the block
    typedef struct {
        logic [NUM_W-1:0] num;
        logic [DEN_W-1:0] den;
        logic             zdiv;
    } t_reduced;

    // predicts the reduced sum of each accepted item and checks results in order
    class reduced_sum_board;
        t_reduced pending_sums[$];
        int       errors;

        function new();
            pending_sums = {};
            errors       = 0;
        endfunction

        function void note_operands(t_op op, logic signed [W-1:0] an, ad, bn, bd);
            longint      p1;
            longint      p2;
            logic [63:0] num;
            logic [63:0] den;
            logic [63:0] num_mag;
            logic [63:0] den_mag;
            logic [63:0] prev;
            logic [63:0] cur;
            logic [63:0] rem;
            logic [63:0] quo;
            bit          num_neg;
            bit          den_neg;
            bit          cur_den_sign;
            bit          gcd_neg;
            t_reduced    res;
            // exact cross products in 64 bits
            p1  = longint'(an) * longint'(bd);
            p2  = longint'(bn) * longint'(ad);
            num = (op == OP_SUB) ? p1 - p2 : p1 + p2;
            den = longint'(ad) * longint'(bd);
            num_neg = num[63];
            den_neg = den[63];
            num_mag = num_neg ? -num : num;
            den_mag = den_neg ? -den : den;
            // euclid on magnitudes, tracking which operand's sign the gcd carries
            prev         = num_mag;
            cur          = den_mag;
            cur_den_sign = 1'b1;
            while (cur != 0) begin
                rem          = prev % cur;
                prev         = cur;
                cur          = rem;
                cur_den_sign = !cur_den_sign;
            end
            gcd_neg = cur_den_sign ? num_neg : den_neg;
            if (prev == 0) begin
                // both zero: flag set and fields cleared
                res.num  = '0;
                res.den  = '0;
                res.zdiv = 1'b1;
            end else begin
                quo      = num_mag / prev;
                quo      = (num_mag != 0 && num_neg != gcd_neg) ? -quo : quo;
                res.num  = quo[NUM_W-1:0];
                quo      = den_mag / prev;
                quo      = (den_mag != 0 && den_neg != gcd_neg) ? -quo : quo;
                res.den  = quo[DEN_W-1:0];
                res.zdiv = 1'b0;
            end
            pending_sums.push_back(res);
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] tdata, logic tuser);
            t_reduced want;
            logic [NUM_W-1:0] got_num;
            logic [DEN_W-1:0] got_den;
            got_num = tdata[NUM_W-1:0];
            got_den = tdata[NUM_W +: DEN_W];
            if (pending_sums.size() == 0) begin
                $display("%0t: unexpected result item num=%0h den=%0h zero_divide=%0b",
                         $time, got_num, got_den, tuser);
                errors++;
                return;
            end
            want = pending_sums.pop_front();
            if (got_num !== want.num) begin
                $display("%0t: res_num mismatch, expected %0h, actual %0h",
                         $time, want.num, got_num);
                errors++;
            end
            if (got_den !== want.den) begin
                $display("%0t: res_den mismatch, expected %0h, actual %0h",
                         $time, want.den, got_den);
                errors++;
            end
            if (tuser !== want.zdiv) begin
                $display("%0t: zero_divide mismatch, expected %0b, actual %0b",
                         $time, want.zdiv, tuser);
                errors++;
            end
        endfunction
    endclass

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    logic [S_TDATA_W-1:0]   i_s_axis_tdata;   // a_num, a_den, b_num, b_den
    logic                   i_s_axis_tuser;   // kind
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready = 1'b1;
    logic [M_TDATA_W-1:0]   o_m_axis_tdata;   // res_num, res_den, zero pad
    logic                   o_m_axis_tuser;   // zero_divide

    reduced_sum_board board;
    int               idle_pct;
    int               stall_pct;

    fraction_add_subtract_reduce #(
        .IN_WIDTH(W)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_s_axis_tvalid(i_s_axis_tvalid),
        .o_s_axis_tready(o_s_axis_tready),
        .i_s_axis_tdata (i_s_axis_tdata),
        .i_s_axis_tuser (i_s_axis_tuser),
        .o_m_axis_tvalid(o_m_axis_tvalid),
        .i_m_axis_tready(i_m_axis_tready),
        .o_m_axis_tdata (o_m_axis_tdata),
        .o_m_axis_tuser (o_m_axis_tuser)
    );

    // clock
    always #2 i_clk = ~i_clk;

    // receiver back-pressure
    always @(negedge i_clk) begin
        i_m_axis_tready = ($urandom_range(0, 99) >= stall_pct);
    end

    // result monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            board.check_result(o_m_axis_tdata, o_m_axis_tuser);
    end

    // operand value: full range, small, extreme, or sharing common factors
    function automatic logic signed [W-1:0] pick_term();
        int                  sel;
        int                  fac;
        logic signed [W-1:0] v;
        sel = $urandom_range(0, 9);
        if (sel < 3) begin
            v = W'($urandom());
        end else if (sel < 6) begin
            v = W'(int'($urandom_range(0, 40)) - 20);
        end else if (sel == 6) begin
            case ($urandom_range(0, 4))
                0: v = -32768;
                1: v = 32767;
                2: v = 0;
                3: v = 1;
                default: v = -1;
            endcase
        end else begin
            case ($urandom_range(0, 4))
                0: fac = 6;
                1: fac = 12;
                2: fac = 210;
                3: fac = 1024;
                default: fac = 2310;
            endcase
            v = W'((int'($urandom_range(0, 60)) - 30) * fac);
        end
        return v;
    endfunction

    // sends one item, entered and left at a falling edge
    task automatic send_item(t_op op, logic signed [W-1:0] an, ad, bn, bd);
        int gap;
        if ($urandom_range(0, 99) < idle_pct) begin
            gap = ($urandom_range(0, 1) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 400);
            i_s_axis_tvalid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_axis_tdata  = {bd, bn, ad, an};
        i_s_axis_tuser  = op;
        i_s_axis_tvalid = 1'b1;
        do @(posedge i_clk); while (!o_s_axis_tready);
        board.note_operands(op, an, ad, bn, bd);
        @(negedge i_clk);
    endtask

    // stimulus and end of run
    initial begin
        board           = new();
        idle_pct        = 0;
        stall_pct       = 0;
        i_rst_n         = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        i_s_axis_tuser  = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: plain sums, zero cases and extremes
        send_item(OP_ADD, 1, 2, 1, 3);
        send_item(OP_SUB, 1, 2, 1, 2);
        send_item(OP_ADD, 0, 5, 0, 7);
        send_item(OP_ADD, 0, 0, 0, 0);
        send_item(OP_SUB, 0, 0, 9, 0);
        send_item(OP_ADD, 3, 0, 5, 7);
        send_item(OP_SUB, -3, 0, 5, 7);
        send_item(OP_ADD, -32768, -32768, -32768, -32768);
        send_item(OP_SUB, -32768, -32768, -32768, -32768);
        send_item(OP_ADD, 32767, 32767, -32768, 1);
        send_item(OP_SUB, 32767, 32767, -32768, 1);
        send_item(OP_ADD, 32767, 1, 32767, 1);
        send_item(OP_SUB, -32768, 1, 32767, 1);
        send_item(OP_SUB, -32768, 32767, 32767, -32768);
        send_item(OP_ADD, -1, -1, 1, -1);
        send_item(OP_SUB, -1, -1, 1, -1);
        send_item(OP_ADD, 1, -2, 1, -3);
        send_item(OP_SUB, 6, -4, -9, 6);
        send_item(OP_ADD, 12, 18, 30, 42);
        send_item(OP_SUB, 1024, 2048, -512, 4096);

        // random phases: no idling, sender idle, receiver stall, both
        for (int phase = 0; phase < 4; phase++) begin
            idle_pct  = (phase == 1) ? 52 : (phase == 3) ? 27 : 0;
            stall_pct = (phase == 2) ? 52 : (phase == 3) ? 27 : 0;
            repeat (450)
                send_item(t_op'($urandom_range(0, 1)),
                          pick_term(), pick_term(), pick_term(), pick_term());
        end
        i_s_axis_tvalid = 1'b0;

        // drain, then allow a spell for any stray result
        while (board.pending_sums.size() != 0) @(posedge i_clk);
        repeat (2000) @(posedge i_clk);
        if (board.errors == 0 && board.pending_sums.size() == 0) begin
            $display("[fraction_add_subtract_reduce] OK");
        end else begin
            $display("[fraction_add_subtract_reduce] ERROR");
        end
        $finish;
    end

    // timeout
    initial begin
        #100_000_000;
        $display("[fraction_add_subtract_reduce] ERROR");
        $finish;
    end

endmodule
